### rtl/nsbc_pkg.sv
// Shared types and character constants for the NMEA sentence block collector.
package nsbc_pkg;

    // Request types on the input channel.
    localparam logic REQ_RX   = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Characters of interest.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Number of stored bytes of a sentence after which the tag is checked.
    localparam int HEADER_LEN = 6;

    // Sentence tags as three stored bytes, oldest byte in the top bits.
    localparam logic [23:0] TAG_RMC = 24'h524D43;
    localparam logic [23:0] TAG_GGA = 24'h474741;
    localparam logic [23:0] TAG_VTG = 24'h565447;

    // Result of one item as it leaves the collector, before the buffer data is known.
    typedef struct packed {
        logic       block_ready;
        logic [8:0] block_length;
        logic       sentence_start;
        logic       seen_rmc;
        logic       seen_gga;
        logic       seen_vtg;
        logic       overflow;
        logic       use_rd;
    } stage_t;

    // Complete result beat.
    typedef struct packed {
        logic       block_ready;
        logic [8:0] block_length;
        logic       sentence_start;
        logic       seen_rmc;
        logic       seen_gga;
        logic       seen_vtg;
        logic       overflow;
        logic [7:0] read_byte;
    } result_t;

endpackage

### rtl/nsbc_buffer_ram.sv
// Block buffer: one write port and one read port with registered read data.
module nsbc_buffer_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [0:DEPTH-1];
    logic [7:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/nsbc_collector.sv
// Collection state: byte count, sentence start, recent bytes, seen flags and buffer access.
module nsbc_collector #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic                 req_type,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           read_index,
    output logic                 ram_wr_en,
    output logic [AW-1:0]        ram_wr_addr,
    output logic [7:0]           ram_wr_data,
    output logic                 ram_rd_en,
    output logic [AW-1:0]        ram_rd_addr,
    output logic                 s1_valid,
    output nsbc_pkg::stage_t     s1_stage
);
    import nsbc_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > 9) ? CW : 9;
    localparam int IW = (AW > 8) ? AW : 8;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] start_reg, start_next;
    logic [23:0]   recent_reg, recent_next;
    logic          rmc_reg, rmc_next;
    logic          gga_reg, gga_next;
    logic          vtg_reg, vtg_next;
    logic          s1_valid_reg;
    stage_t        s1_stage_reg, stage_next;

    logic          is_read, is_eol, is_store, full, all_seen, hit;
    logic [CW-1:0] base_count, base_start, count_store, len_cw;
    logic [23:0]   base_recent;
    logic          base_rmc, base_gga, base_vtg;
    logic [LW-1:0] len_wide;
    logic [IW-1:0] idx_wide;
    logic          in_range;

    assign is_read  = (req_type == REQ_READ);
    assign is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    assign is_store = !is_read && !is_eol;
    assign full     = (count_reg >= CW'(DEPTH));
    assign all_seen = rmc_reg && gga_reg && vtg_reg;

    // A full buffer restarts collection before a stored byte is handled.
    assign base_count  = full ? '0 : count_reg;
    assign base_start  = full ? '0 : start_reg;
    assign base_recent = full ? '0 : recent_reg;
    assign base_rmc    = full ? 1'b0 : rmc_reg;
    assign base_gga    = full ? 1'b0 : gga_reg;
    assign base_vtg    = full ? 1'b0 : vtg_reg;
    assign count_store = base_count + CW'(1);

    // Read range check against the buffer depth.
    assign in_range = (11'(read_index) < 11'(DEPTH));
    assign idx_wide = IW'(read_index);

    // Next state and the result of this item.
    always_comb begin
        count_next  = count_reg;
        start_next  = start_reg;
        recent_next = recent_reg;
        rmc_next    = rmc_reg;
        gga_next    = gga_reg;
        vtg_next    = vtg_reg;
        len_cw      = count_reg;
        hit         = 1'b0;
        stage_next  = '0;

        if (is_read) begin
            stage_next.use_rd = in_range;
        end else if (is_eol) begin
            // End of line with every tag seen closes the block.
            if (all_seen) begin
                stage_next.block_ready    = 1'b1;
                stage_next.sentence_start = 1'b1;
                count_next  = '0;
                start_next  = '0;
                recent_next = '0;
                rmc_next    = 1'b0;
                gga_next    = 1'b0;
                vtg_next    = 1'b0;
            end
        end else begin
            stage_next.overflow = full;
            start_next = base_start;
            if (rx_byte == CH_DOLLAR) begin
                stage_next.sentence_start = 1'b1;
                start_next = base_count;
            end
            count_next  = count_store;
            recent_next = {base_recent[15:0], rx_byte};
            hit         = ((count_store - start_next) == CW'(HEADER_LEN));
            rmc_next    = base_rmc || (hit && (recent_next == TAG_RMC));
            gga_next    = base_gga || (hit && (recent_next == TAG_GGA));
            vtg_next    = base_vtg || (hit && (recent_next == TAG_VTG));
            len_cw      = count_store;
        end

        len_wide                = LW'(len_cw);
        stage_next.block_length = len_wide[8:0];
        stage_next.seen_rmc     = rmc_next;
        stage_next.seen_gga     = gga_next;
        stage_next.seen_vtg     = vtg_next;
    end

    // Control state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            start_reg    <= '0;
            recent_reg   <= '0;
            rmc_reg      <= 1'b0;
            gga_reg      <= 1'b0;
            vtg_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_fire;
            if (in_fire) begin
                count_reg  <= count_next;
                start_reg  <= start_next;
                recent_reg <= recent_next;
                rmc_reg    <= rmc_next;
                gga_reg    <= gga_next;
                vtg_reg    <= vtg_next;
            end
        end
    end

    // Result is registered alongside the buffer read.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_stage_reg <= stage_next;
        end
    end

    assign ram_wr_en   = in_fire && is_store;
    assign ram_wr_addr = base_count[AW-1:0];
    assign ram_wr_data = rx_byte;
    assign ram_rd_en   = in_fire && is_read && in_range;
    assign ram_rd_addr = idx_wide[AW-1:0];
    assign s1_valid    = s1_valid_reg;
    assign s1_stage    = s1_stage_reg;

`ifndef ASSERT_OFF
    // The count never passes the buffer depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("byte count beyond buffer depth");
    // A completed block leaves all flags and the count cleared.
    a_block_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && is_eol && !is_read && all_seen) |=>
            (count_reg == '0) && !rmc_reg && !gga_reg && !vtg_reg)
        else $error("completed block did not clear collection state");
    // Stored bytes never go beyond the buffer.
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (CW'(ram_wr_addr) < CW'(DEPTH)))
        else $error("buffer write beyond depth");
`endif

endmodule

### rtl/nsbc_out_queue.sv
// Three-entry result queue that decouples the result channel from the collector.
module nsbc_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  nsbc_pkg::result_t   push_data,
    input  logic                pop_ready,
    output logic                head_valid,
    output nsbc_pkg::result_t   head_data,
    output logic [1:0]          fill
);
    import nsbc_pkg::*;

    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    result_t    slot2_reg, slot2_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] wr_pos;
    logic       pop;

    assign pop    = (cnt_reg != 2'd0) && pop_ready;
    assign wr_pos = cnt_reg - {1'b0, pop};

    // Slot zero is always the head; entries shift toward it on a pop, and a push lands
    // in the first free slot after that shift.
    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        slot2_next = slot2_reg;
        if (pop) begin
            slot0_next = slot1_reg;
            slot1_next = slot2_reg;
        end
        if (push) begin
            case (wr_pos)
                2'd0: begin
                    slot0_next = push_data;
                end
                2'd1: begin
                    slot1_next = push_data;
                end
                2'd2: begin
                    slot2_next = push_data;
                end
                default: begin
                end
            endcase
        end
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
        slot2_reg <= slot2_next;
    end

    assign head_valid = (cnt_reg != 2'd0);
    assign head_data  = slot0_reg;
    assign fill       = cnt_reg;

endmodule

### rtl/nmea_sentence_block_collector_core.sv
// Top level of the NMEA sentence block collector: buffer RAM, collector and result queue.
//
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_valid / s_ready  | req_type, rx_byte, read_index
//  m_      | out       | m_valid / m_ready  | block_ready, block_length, sentence_start,
//          |           |                    | seen_rmc, seen_gga, seen_vtg, overflow, read_byte
//
// One beat is accepted per cycle while s_ready is high. Its result is registered with the
// buffer read data on acceptance, then enters the result queue and leaves from its head.
// State updates in the cycle of acceptance, so back-to-back bytes need no forwarding.
// Reset is synchronous (aresetn low) and clears count, flags and the pipeline; the buffer
// holds no reset value and needs no clearing pass.
// Input is taken while fewer than three results are in flight and the queue holds three, so
// a stalled result channel lets at most three results wait before s_ready drops.
module nmea_sentence_block_collector_core #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_rx_byte,
    input  logic [7:0] s_read_index,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_block_ready,
    output logic [8:0] m_block_length,
    output logic       m_sentence_start,
    output logic       m_seen_rmc,
    output logic       m_seen_gga,
    output logic       m_seen_vtg,
    output logic       m_overflow,
    output logic [7:0] m_read_byte
);
    import nsbc_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic          in_fire;
    logic          ram_wr_en, ram_rd_en;
    logic [AW-1:0] ram_wr_addr, ram_rd_addr;
    logic [7:0]    ram_wr_data, ram_rd_data;
    logic          s1_valid;
    stage_t        s1_stage;
    result_t       push_data, head_data;
    logic [1:0]    q_fill;
    logic [2:0]    in_flight;

    // Credit check: in-flight results never exceed what the queue can absorb.
    assign in_flight = 3'(q_fill) + 3'(s1_valid);
    assign s_ready   = (in_flight < 3'd3);
    assign in_fire   = s_valid && s_ready;

    nsbc_collector #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_collector (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .req_type    (s_req_type),
        .rx_byte     (s_rx_byte),
        .read_index  (s_read_index),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .s1_valid    (s1_valid),
        .s1_stage    (s1_stage)
    );

    nsbc_buffer_ram #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_buffer_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Merge the buffer read data into the result.
    always_comb begin
        push_data.block_ready    = s1_stage.block_ready;
        push_data.block_length   = s1_stage.block_length;
        push_data.sentence_start = s1_stage.sentence_start;
        push_data.seen_rmc       = s1_stage.seen_rmc;
        push_data.seen_gga       = s1_stage.seen_gga;
        push_data.seen_vtg       = s1_stage.seen_vtg;
        push_data.overflow       = s1_stage.overflow;
        push_data.read_byte      = s1_stage.use_rd ? ram_rd_data : 8'h00;
    end

    nsbc_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s1_valid),
        .push_data  (push_data),
        .pop_ready  (m_ready),
        .head_valid (m_valid),
        .head_data  (head_data),
        .fill       (q_fill)
    );

    assign m_block_ready    = head_data.block_ready;
    assign m_block_length   = head_data.block_length;
    assign m_sentence_start = head_data.sentence_start;
    assign m_seen_rmc       = head_data.seen_rmc;
    assign m_seen_gga       = head_data.seen_gga;
    assign m_seen_vtg       = head_data.seen_vtg;
    assign m_overflow       = head_data.overflow;
    assign m_read_byte      = head_data.read_byte;

`ifndef ASSERT_OFF
    // The queue is never pushed while full without a pop in the same cycle.
    a_no_queue_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s1_valid && (q_fill == 2'd3) && !m_ready))
        else $error("result queue overrun");
    // Every accepted beat enters the read stage on the next edge.
    a_accept_to_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> s1_valid)
        else $error("accepted beat lost before the read stage");
    // A completed block is always reported as a sentence start with cleared flags.
    a_ready_implies_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_block_ready) |->
            (m_sentence_start && !m_seen_rmc && !m_seen_gga && !m_seen_vtg))
        else $error("block ready without start or with flags set");
`endif

endmodule
